// File: rtl/core/tts_pkg.sv
// ----------------------------------------------------------------------------
// Timed task slot scheduler package
// Word layouts, command codes and field widths used by the scheduler unit.
// ----------------------------------------------------------------------------
package tts_pkg;

	// Field widths of the command and result words, and of the sleep counter.
	localparam int unsigned KIND_W       = 3;
	localparam int unsigned SLOT_FIELD_W = 6;
	localparam int unsigned TICK_W       = 64;
	localparam int unsigned MODE_W       = 2;
	localparam int unsigned SLEEP_W      = 8;

	// Command kinds.
	typedef enum logic [KIND_W-1:0] {
		KIND_REGISTER   = 3'd0,
		KIND_UNREGISTER = 3'd1,
		KIND_PLAN       = 3'd2,
		KIND_SPIN       = 3'd3,
		KIND_SLEEP_OFF  = 3'd4,
		KIND_SLEEP_ON   = 3'd5
	} tts_kind_t;

	// Plan modes.
	localparam logic [MODE_W-1:0] MODE_ABSOLUTE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LAST_SPIN = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FROM_NOW  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_IMMEDIATE = 2'd3;

	// Command word.
	typedef struct packed {
		logic [KIND_W-1:0]       kind;
		logic [SLOT_FIELD_W-1:0] slot_id;
		logic [TICK_W-1:0]       tick_value;
		logic [MODE_W-1:0]       plan_mode;
		logic                    use_current;
		logic [TICK_W-1:0]       now_tick;
	} tts_item_t;

	// Result word.
	typedef struct packed {
		logic [SLOT_FIELD_W-1:0] task_slot;
		logic                    task_valid;
		logic [TICK_W-1:0]       next_tick;
		logic                    respin;
		logic                    sleep_allowed;
		logic                    full_error;
		logic                    last;
	} tts_result_t;

endpackage

// File: rtl/core/tts_due_mem.sv
// ----------------------------------------------------------------------------
// Due tick store
// One write port and one registered read port. An entry that has never been
// written reads as zero, which is the reset value of every due tick.
// ----------------------------------------------------------------------------
module tts_due_mem #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned WIDTH = 64,
	parameter int unsigned AW    = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] written_q;
	logic [WIDTH-1:0] raw_q;
	logic             hit_q;

	// Storage array and its registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		raw_q <= mem[rd_addr];
	end

	// Written marks, cleared at once by reset, read alongside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			hit_q     <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			hit_q <= written_q[rd_addr];
		end
	end

	assign rd_data = hit_q ? raw_q : '0;

endmodule

// File: rtl/core/timed_task_slot_scheduler_unit.sv
// ----------------------------------------------------------------------------
// Timed task slot scheduler
// Keeps a table of task slots with active marks and due ticks, and serves
// register, unregister, plan, spin and sleep counter commands one at a time.
// ----------------------------------------------------------------------------
// Unregister, the sleep and spare commands and a plan of a slot out of range end in ST_CALC;
// a plan goes on to ST_PLAN; a register walks ST_FIND, then ST_PLAN if a slot is free.
// A spin walks the due tick store in ST_SCAN at one slot per cycle on its single read port;
// a dispatched word is held back until the next dispatch or the summary word. No stalls.
// busy drops with the final word, so the next command is taken at the edge that ends it.
// Reset clears the scheduler state at once; a command is taken in the first cycle after.
module timed_task_slot_scheduler_unit import tts_pkg::*; #(
	parameter int unsigned TASK_SLOTS = 64,
	parameter int unsigned TICK_BITS  = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  tts_item_t   item,
	output logic        result_strobe,
	output tts_result_t result
);

	localparam int unsigned SLOT_W = $clog2(TASK_SLOTS);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASK_SLOTS - 1);
	localparam logic [SLOT_FIELD_W:0] SLOT_LIMIT = (SLOT_FIELD_W + 1)'(TASK_SLOTS);

	// Sequencer states.
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CALC  = 6'b000010,
		ST_FIND  = 6'b000100,
		ST_PLAN  = 6'b001000,
		ST_SCAN  = 6'b010000,
		ST_FINAL = 6'b100000
	} tts_state_t;

	tts_state_t state_q, state_d;

	// Scheduler state.
	logic [TASK_SLOTS-1:0] active_q, active_d;
	logic [TICK_BITS-1:0]  earliest_q, earliest_d;
	logic                  pend_q, pend_d;
	logic [TICK_BITS-1:0]  last_spin_q, last_spin_d;
	logic [SLOT_W-1:0]     cur_slot_q, cur_slot_d;
	logic [SLEEP_W-1:0]    sleep_q, sleep_d;

	// Latched command word.
	logic [KIND_W-1:0]       kind_q;
	logic [SLOT_FIELD_W-1:0] sid_q;
	logic [TICK_BITS-1:0]    tv_q;
	logic [MODE_W-1:0]       mode_q;
	logic                    use_cur_q;
	logic [TICK_BITS-1:0]    now_q;

	// Working registers of the sequencer.
	logic [SLOT_W-1:0]    idx_q, idx_d;
	logic [SLOT_W-1:0]    slot_q, slot_d;
	logic [TICK_BITS-1:0] t_q, t_d;
	logic [TICK_BITS-1:0] min_q, min_d;
	logic [SLOT_W-1:0]    hold_q, hold_d;
	logic                 have_q, have_d;
	logic                 go_q, go_d;

	// Result register.
	tts_result_t res_q, res_d;
	logic        res_vld_q, res_vld_d;

	// Due tick store port.
	logic                 mem_we;
	logic [SLOT_W-1:0]    mem_waddr;
	logic [TICK_BITS-1:0] mem_wdata;
	logic [SLOT_W-1:0]    mem_raddr;
	logic [TICK_BITS-1:0] mem_rdata;

	// Shared adder for planned ticks.
	logic [TICK_BITS-1:0] plan_base;
	logic [TICK_BITS-1:0] plan_tick;
	logic                 sid_ok;
	logic                 accept;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign sid_ok = ({1'b0, sid_q} < SLOT_LIMIT);

	always_comb begin
		case (mode_q)
			MODE_LAST_SPIN: plan_base = last_spin_q;
			MODE_FROM_NOW:  plan_base = now_q;
			default:        plan_base = '0;
		endcase
		plan_tick = (mode_q == MODE_IMMEDIATE) ? '0 : (plan_base + tv_q);
	end

	tts_due_mem #(
		.DEPTH (TASK_SLOTS),
		.WIDTH (TICK_BITS),
		.AW    (SLOT_W)
	) u_due_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_addr (mem_raddr),
		.rd_data (mem_rdata)
	);

	// Sequencer: next state, table updates and result words.
	always_comb begin
		state_d     = state_q;
		active_d    = active_q;
		earliest_d  = earliest_q;
		pend_d      = pend_q;
		last_spin_d = last_spin_q;
		cur_slot_d  = cur_slot_q;
		sleep_d     = sleep_q;
		idx_d       = idx_q;
		slot_d      = slot_q;
		t_d         = t_q;
		min_d       = min_q;
		hold_d      = hold_q;
		have_d      = have_q;
		go_d        = go_q;
		res_d       = '0;
		res_vld_d   = 1'b0;
		mem_we      = 1'b0;
		mem_waddr   = idx_q;
		mem_wdata   = '1;
		mem_raddr   = '0;

		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_CALC;
				end
			end

			ST_CALC: begin
				// Single-step commands finish here with a plain final word.
				state_d = ST_IDLE;
				case (kind_q)
					KIND_REGISTER: begin
						idx_d   = '0;
						state_d = ST_FIND;
					end
					KIND_UNREGISTER: begin
						if (sid_ok) begin
							active_d[sid_q[SLOT_W-1:0]] = 1'b0;
						end
					end
					KIND_PLAN: begin
						t_d    = plan_tick;
						slot_d = use_cur_q ? cur_slot_q : sid_q[SLOT_W-1:0];
						if (use_cur_q || sid_ok) begin
							state_d = ST_PLAN;
						end
					end
					KIND_SPIN: begin
						last_spin_d = now_q;
						go_d        = (now_q > earliest_q);
						min_d       = '1;
						have_d      = 1'b0;
						idx_d       = '0;
						mem_raddr   = '0;
						state_d     = ST_SCAN;
					end
					KIND_SLEEP_OFF: begin
						sleep_d = sleep_q + SLEEP_W'(1);
					end
					KIND_SLEEP_ON: begin
						sleep_d = sleep_q - SLEEP_W'(1);
					end
					default: begin
					end
				endcase
				if (state_d == ST_IDLE) begin
					res_vld_d           = 1'b1;
					res_d.last          = 1'b1;
					res_d.sleep_allowed = (sleep_d == '0);
				end
			end

			ST_FIND: begin
				// Walk the active marks for the lowest free slot.
				if (!active_q[idx_q]) begin
					slot_d  = idx_q;
					t_d     = tv_q;
					state_d = ST_PLAN;
				end else if (idx_q == LAST_SLOT) begin
					res_vld_d           = 1'b1;
					res_d.full_error    = 1'b1;
					res_d.last          = 1'b1;
					res_d.sleep_allowed = (sleep_q == '0);
					state_d             = ST_IDLE;
				end else begin
					idx_d = idx_q + SLOT_W'(1);
				end
			end

			ST_PLAN: begin
				// Store the due tick and track the earliest planned tick.
				mem_we    = 1'b1;
				mem_waddr = slot_q;
				mem_wdata = t_q;
				if (earliest_q >= t_q) begin
					earliest_d = t_q;
					if (t_q <= now_q) begin
						pend_d = 1'b1;
					end
				end
				res_vld_d           = 1'b1;
				res_d.last          = 1'b1;
				res_d.sleep_allowed = (sleep_q == '0);
				if (kind_q == KIND_REGISTER) begin
					active_d[slot_q] = 1'b1;
					res_d.task_slot  = SLOT_FIELD_W'(slot_q);
					res_d.task_valid = 1'b1;
				end
				state_d = ST_IDLE;
			end

			ST_SCAN: begin
				// One slot per cycle: an active slot is dispatched if due, else folded into the minimum.
				// A dispatched word is held back until the next one or the summary.
				mem_raddr = (idx_q == LAST_SLOT) ? '0 : (idx_q + SLOT_W'(1));
				if (active_q[idx_q]) begin
					if (go_q && (mem_rdata <= now_q)) begin
						mem_we     = 1'b1;
						mem_waddr  = idx_q;
						mem_wdata  = '1;
						cur_slot_d = idx_q;
						hold_d     = idx_q;
						have_d     = 1'b1;
						if (have_q) begin
							res_vld_d        = 1'b1;
							res_d.task_slot  = SLOT_FIELD_W'(hold_q);
							res_d.task_valid = 1'b1;
						end
					end else if (mem_rdata < min_q) begin
						min_d = mem_rdata;
					end
				end
				if (idx_q == LAST_SLOT) begin
					state_d = ST_FINAL;
				end else begin
					idx_d = idx_q + SLOT_W'(1);
				end
			end

			ST_FINAL: begin
				// Summary word of a spin.
				res_vld_d           = 1'b1;
				res_d.task_slot     = have_q ? SLOT_FIELD_W'(hold_q) : '0;
				res_d.task_valid    = have_q;
				res_d.next_tick     = TICK_W'(min_q);
				res_d.sleep_allowed = (sleep_q == '0);
				res_d.last          = 1'b1;
				if (go_q) begin
					if (pend_q) begin
						pend_d       = 1'b0;
						res_d.respin = 1'b1;
					end else begin
						res_d.respin = (min_q < now_q);
					end
				end
				state_d = ST_IDLE;
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control and scheduler state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			active_q    <= '0;
			earliest_q  <= '0;
			pend_q      <= 1'b0;
			last_spin_q <= '0;
			cur_slot_q  <= '0;
			sleep_q     <= '0;
			res_vld_q   <= 1'b0;
		end else begin
			state_q     <= state_d;
			active_q    <= active_d;
			earliest_q  <= earliest_d;
			pend_q      <= pend_d;
			last_spin_q <= last_spin_d;
			cur_slot_q  <= cur_slot_d;
			sleep_q     <= sleep_d;
			res_vld_q   <= res_vld_d;
		end
	end

	// Command latch, working registers and result word.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q    <= item.kind;
			sid_q     <= item.slot_id;
			tv_q      <= item.tick_value[TICK_BITS-1:0];
			mode_q    <= item.plan_mode;
			use_cur_q <= item.use_current;
			now_q     <= item.now_tick[TICK_BITS-1:0];
		end
		idx_q  <= idx_d;
		slot_q <= slot_d;
		t_q    <= t_d;
		min_q  <= min_d;
		hold_q <= hold_d;
		have_q <= have_d;
		go_q   <= go_d;
		if (res_vld_d) begin
			res_q <= res_d;
		end
	end

	assign result_strobe = res_vld_q;
	assign result        = res_q;

`ifndef SYNTH
	// The block goes idle only together with the final word of a command.
	a_idle_with_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (result_strobe && result.last))
		else $error("busy fell without a final result word");

	// A final word always leaves the block ready for the next command.
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && result.last) |-> !busy)
		else $error("final result word while still busy");

	// Words before the final one are dispatched tasks within a spin.
	a_mid_words: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && !result.last) |-> (busy && result.task_valid))
		else $error("intermediate result word outside a spin dispatch");

	// A full table answers with no slot.
	a_full_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && result.full_error) |-> (!result.task_valid && result.last))
		else $error("full table result carries a slot");
`endif

endmodule
